/* rtl/core/nbc64_pkg.sv */
// ----------------------------------------------------------------------------
// nbc64_pkg
// Types, constants and round functions for the 64-bit nibble block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package nbc64_pkg;

  localparam int unsigned BlockW  = 64;
  localparam int unsigned RoundW  = 6;
  localparam int unsigned NibbleN = 16;

  localparam logic [BlockW-1:0] RoundConst = 64'h3;
  localparam logic [BlockW-1:0] KeyAddMask = 64'hFFFF_FFFF_0000_0000;

  localparam logic [3:0] FwdSbox [NibbleN] = '{
    4'h2, 4'h4, 4'h5, 4'h6, 4'h1, 4'hA, 4'hF, 4'h3,
    4'hB, 4'hE, 4'h0, 4'h7, 4'h9, 4'h8, 4'hC, 4'hD
  };

  localparam logic [3:0] InvSbox [NibbleN] = '{
    4'hA, 4'h4, 4'h0, 4'h7, 4'h1, 4'h2, 4'h3, 4'hB,
    4'hD, 4'hC, 4'h5, 4'h8, 4'hE, 4'hF, 4'h9, 4'h6
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_ROUND,
    ST_DONE
  } nbc64_state_e;

  typedef struct packed {
    logic load;
    logic key_fwd;
    logic round;
  } nbc64_cmd_t;

  function automatic logic [BlockW-1:0] sub_fwd(input logic [BlockW-1:0] v);
    logic [BlockW-1:0] r;
    r = '0;
    for (int k = 0; k < NibbleN; k++) begin
      r[4*k +: 4] = FwdSbox[v[4*k +: 4]];
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] sub_inv(input logic [BlockW-1:0] v);
    logic [BlockW-1:0] r;
    r = '0;
    for (int k = 0; k < NibbleN; k++) begin
      r[4*k +: 4] = InvSbox[v[4*k +: 4]];
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] mix_fwd(input logic [BlockW-1:0] v);
    logic [3:0] a [NibbleN];
    logic [3:0] b [NibbleN];
    logic [BlockW-1:0] r;
    r = '0;
    for (int k = 0; k < NibbleN; k++) begin
      a[k] = v[4*k +: 4];
    end
    for (int i = 0; i < 4; i++) begin
      b[i+12] = a[i+12] ^ a[((i+2) & 3) + 4];
      b[i+8]  = a[((i+3) & 3) + 8] ^ a[((i+2) & 3) + 4];
      b[i+4]  = a[i+12] ^ a[(i+1) & 3];
      b[i]    = a[((i+2) & 3) + 4];
    end
    for (int k = 0; k < NibbleN; k++) begin
      r[4*k +: 4] = b[k];
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] mix_inv(input logic [BlockW-1:0] v);
    logic [3:0] a [NibbleN];
    logic [3:0] b [NibbleN];
    logic [BlockW-1:0] r;
    r = '0;
    for (int k = 0; k < NibbleN; k++) begin
      a[k] = v[4*k +: 4];
    end
    for (int i = 0; i < 4; i++) begin
      b[i+12]              = a[i+12] ^ a[i];
      b[((i+3) & 3) + 8]   = a[i+8] ^ a[i];
      b[((i+2) & 3) + 4]   = a[i];
      b[(i+1) & 3]         = a[i+12] ^ a[i+4] ^ a[i];
    end
    for (int k = 0; k < NibbleN; k++) begin
      r[4*k +: 4] = b[k];
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] key_next(input logic [BlockW-1:0] k);
    logic [BlockW-1:0] t;
    t = k ^ RoundConst;
    return {t[15:0], t[63:16]};
  endfunction

  function automatic logic [BlockW-1:0] key_prev(input logic [BlockW-1:0] k);
    return {k[47:0], k[63:48]} ^ RoundConst;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/nbc64_dp.sv */
// ----------------------------------------------------------------------------
// nbc64_dp
// Datapath: block and key regs, one cipher round per cycle of cmd_i.round.
// ----------------------------------------------------------------------------
`default_nettype none

module nbc64_dp import nbc64_pkg::*; (
  input  wire logic              clk_i,
  input  wire nbc64_cmd_t        cmd_i,
  input  wire logic              mode_i,
  input  wire logic [BlockW-1:0] block_in_i,
  input  wire logic [BlockW-1:0] cipher_key_i,
  output logic      [BlockW-1:0] block_o
);

  logic [BlockW-1:0] block_q, block_d;
  logic [BlockW-1:0] key_q, key_d;
  logic              dec_q, dec_d;
  logic [BlockW-1:0] key_back;

  always_comb begin
    block_d  = block_q;
    key_d    = key_q;
    dec_d    = dec_q;
    key_back = key_prev(key_q);
    if (cmd_i.load) begin
      block_d = block_in_i;
      key_d   = cipher_key_i;
      dec_d   = mode_i;
    end else if (cmd_i.key_fwd) begin
      key_d = key_next(key_q);
    end else if (cmd_i.round) begin
      if (dec_q) begin
        block_d = sub_inv(mix_inv(block_q)) ^ (key_back & KeyAddMask);
        key_d   = key_back;
      end else begin
        block_d = mix_fwd(sub_fwd(block_q ^ (key_q & KeyAddMask)));
        key_d   = key_next(key_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    block_q <= block_d;
    key_q   <= key_d;
    dec_q   <= dec_d;
  end

  assign block_o = block_q;

endmodule

`default_nettype wire

/* rtl/core/nbc64_ctrl.sv */
// ----------------------------------------------------------------------------
// nbc64_ctrl
// Controller: sequences key advance and cipher rounds and counts them.
// ----------------------------------------------------------------------------
`default_nettype none

module nbc64_ctrl import nbc64_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              mode_i,
  input  wire logic [RoundW-1:0] round_count_i,
  output nbc64_cmd_t             cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);

  localparam int unsigned CntW = $clog2(MAX_ROUNDS + 1);
  localparam logic [RoundW-1:0] MaxRounds = RoundW'(MAX_ROUNDS);

  nbc64_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] nrnd_q, nrnd_d;
  logic [RoundW-1:0] rounds_sat;
  logic [CntW-1:0] rounds;

  always_comb begin
    rounds_sat = (round_count_i > MaxRounds) ? MaxRounds : round_count_i;
    rounds     = rounds_sat[CntW-1:0];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    nrnd_d  = nrnd_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = rounds;
          nrnd_d     = rounds;
          if (rounds == '0) begin
            state_d = ST_DONE;
          end else if (mode_i) begin
            state_d = ST_KEY;
          end else begin
            state_d = ST_ROUND;
          end
        end
      end
      ST_KEY: begin
        cmd_o.key_fwd = 1'b1;
        if (cnt_q == CntW'(1)) begin
          cnt_d   = nrnd_q;
          state_d = ST_ROUND;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        cnt_d       = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      nrnd_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nrnd_q  <= nrnd_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/nibble_block_cipher_64_top.sv */
// ----------------------------------------------------------------------------
// nibble_block_cipher_64_top
// 64-bit nibble block cipher with APB round-count register.
// ----------------------------------------------------------------------------
// The done_o beat follows the accepted start beat after n cipher rounds for
// encryption, and after n key advances and then n rounds for decryption, where
// n is round_count saturated to MAX_ROUNDS. The single round unit does one
// round or one key advance per cycle. A new block is taken in the cycle after
// done_o. Reset returns the controller to idle and round_count to four.
`default_nettype none

module nibble_block_cipher_64_top import nbc64_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              mode_i,
  input  wire logic [BlockW-1:0] block_in_i,
  input  wire logic [BlockW-1:0] cipher_key_i,
  output logic                   done_o,
  output logic      [BlockW-1:0] block_out_o
);

  logic [RoundW-1:0] round_count_q, round_count_d;
  logic              reg_hit;
  nbc64_cmd_t        cmd;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);

  always_comb begin
    round_count_d = round_count_q;
    if (psel && penable && pwrite && reg_hit) begin
      round_count_d = pwdata[RoundW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(32-RoundW){1'b0}}, round_count_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= RoundW'(4);
    end else begin
      round_count_q <= round_count_d;
    end
  end

  nbc64_ctrl #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i       (start),
    .mode_i,
    .round_count_i (round_count_q),
    .cmd_o         (cmd),
    .busy_o        (busy),
    .done_o
  );

  nbc64_dp u_dp (
    .clk_i,
    .cmd_i        (cmd),
    .mode_i,
    .block_in_i,
    .cipher_key_i,
    .block_o      (block_out_o)
  );

endmodule

`default_nettype wire

/* rtl/core/nbc64_checker.sv */
// ----------------------------------------------------------------------------
// nbc64_checker
// Port-level checks of the start, busy and done sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module nbc64_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);

  // An accepted beat makes the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy low after an accepted start beat");

  // A result beat is only shown while the block is busy.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("done_o high while idle");

  // The block is idle again right after a result beat.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("block not idle after a result beat");

  // A result always follows a busy cycle or an accepted start beat.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(busy) || $past(start))
    else $error("done_o without a preceding start beat");

endmodule

bind nibble_block_cipher_64_top nbc64_checker u_nbc64_checker (
  .clk_i,
  .rst_ni,
  .start,
  .busy,
  .done_o
);

`default_nettype wire

/* bench/nibble_block_cipher_64_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nibble_block_cipher_64_top_tb
// Self-checking bench for the 64-bit nibble block cipher. Blocks are sent
// through the start/busy command port in both modes under several round
// counts written and read back over APB. A scoreboard runs the cipher rounds
// and the key schedule for every accepted beat and compares each done_o beat
// with the oldest prediction.
// ----------------------------------------------------------------------------
module nibble_block_cipher_64_top_tb;
  import nbc64_pkg::BlockW;

  localparam logic        MODE_ENCRYPT     = 1'b0;
  localparam logic        MODE_DECRYPT     = 1'b1;
  localparam logic [2:0]  ADDR_ROUND_COUNT = 3'd0;
  localparam int unsigned MAX_ROUNDS       = 32;
  localparam int unsigned TAIL_CYCLES      = 2 * MAX_ROUNDS + 8;
  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned ITEMS_PER_PHASE  = 134;
  localparam int unsigned PHASE_COUNT      = 6;
  localparam int unsigned MAX_REPORTS      = 10;

  class cipher_scoreboard;
    localparam bit [63:0] SBOX_FWD = 64'hDC89_70EB_3FA1_6542;
    localparam bit [63:0] SBOX_INV = 64'h69FE_85CD_B321_704A;
    localparam bit [63:0] KEY_HALF = 64'hFFFF_FFFF_0000_0000;
    localparam bit [63:0] KEY_CONST = 64'h3;

    bit [BlockW-1:0] expected_blocks[$];
    bit [5:0]        round_count = 6'd4;
    int unsigned     failures;
    int unsigned     checked;
    int unsigned     encrypted;
    int unsigned     decrypted;

    function int unsigned active_rounds();
      return (round_count > MAX_ROUNDS) ? MAX_ROUNDS : round_count;
    endfunction

    function int unsigned pending();
      return expected_blocks.size();
    endfunction

    function bit [63:0] substitute(bit [63:0] v, bit [63:0] box);
      bit [63:0] r;
      for (int k = 0; k < 16; k++) begin
        r[4*k +: 4] = box[{v[4*k +: 4], 2'b00} +: 4];
      end
      return r;
    endfunction

    function bit [63:0] mix_forward(bit [63:0] v);
      bit [3:0]  a [16];
      bit [3:0]  b [16];
      bit [63:0] r;
      for (int k = 0; k < 16; k++) begin
        a[k] = v[4*k +: 4];
      end
      for (int i = 0; i < 4; i++) begin
        b[12 + i] = a[12 + i] ^ a[4 + ((i + 2) % 4)];
        b[8 + i]  = a[8 + ((i + 3) % 4)] ^ a[4 + ((i + 2) % 4)];
        b[4 + i]  = a[12 + i] ^ a[(i + 1) % 4];
        b[i]      = a[4 + ((i + 2) % 4)];
      end
      for (int k = 0; k < 16; k++) begin
        r[4*k +: 4] = b[k];
      end
      return r;
    endfunction

    function bit [63:0] mix_inverse(bit [63:0] v);
      bit [3:0]  a [16];
      bit [3:0]  b [16];
      bit [63:0] r;
      for (int k = 0; k < 16; k++) begin
        a[k] = v[4*k +: 4];
      end
      for (int i = 0; i < 4; i++) begin
        b[12 + i]             = a[12 + i] ^ a[i];
        b[8 + ((i + 3) % 4)]  = a[8 + i] ^ a[i];
        b[4 + ((i + 2) % 4)]  = a[i];
        b[(i + 1) % 4]        = a[12 + i] ^ a[4 + i] ^ a[i];
      end
      for (int k = 0; k < 16; k++) begin
        r[4*k +: 4] = b[k];
      end
      return r;
    endfunction

    function bit [63:0] key_advance(bit [63:0] k);
      bit [63:0] t;
      t = k ^ KEY_CONST;
      return {t[15:0], t[63:16]};
    endfunction

    function bit [63:0] key_retreat(bit [63:0] k);
      return {k[47:0], k[63:48]} ^ KEY_CONST;
    endfunction

    function bit [BlockW-1:0] cipher_result(bit mode, bit [63:0] blk, bit [63:0] key);
      bit [63:0]   w;
      bit [63:0]   k;
      int unsigned n;
      w = blk;
      k = key;
      n = active_rounds();
      if (mode == MODE_ENCRYPT) begin
        for (int r = 0; r < n; r++) begin
          w = mix_forward(substitute(w ^ (k & KEY_HALF), SBOX_FWD));
          k = key_advance(k);
        end
      end else begin
        for (int r = 0; r < n; r++) begin
          k = key_advance(k);
        end
        for (int r = 0; r < n; r++) begin
          k = key_retreat(k);
          w = substitute(mix_inverse(w), SBOX_INV) ^ (k & KEY_HALF);
        end
      end
      return w;
    endfunction

    function void note_block(bit mode, bit [63:0] blk, bit [63:0] key);
      expected_blocks.push_back(cipher_result(mode, blk, key));
      if (mode == MODE_ENCRYPT) encrypted++;
      else decrypted++;
    endfunction

    function void check_block(logic [BlockW-1:0] actual);
      bit [BlockW-1:0] expected;
      if (expected_blocks.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("ERROR: block_out beat %h with no block outstanding", actual);
        end
        return;
      end
      expected = expected_blocks.pop_front();
      checked++;
      if (actual !== expected) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("ERROR: block_out mismatch at %0d rounds: expected %h, got %h",
                   round_count, expected, actual);
        end
      end
    endfunction

    function void check_register(bit [5:0] written, logic [31:0] read);
      if (read[5:0] !== written) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("ERROR: round_count readback: expected %0d, got %h", written, read);
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              start;
  logic              busy;
  logic              mode_i;
  logic [BlockW-1:0] block_in_i;
  logic [BlockW-1:0] cipher_key_i;
  logic              done_o;
  logic [BlockW-1:0] block_out_o;

  cipher_scoreboard  sb = new();
  int unsigned       cycle_count;
  int unsigned       settings_used;

  nibble_block_cipher_64_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .block_in_i   (block_in_i),
    .cipher_key_i (cipher_key_i),
    .done_o       (done_o),
    .block_out_o  (block_out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d blocks outstanding",
               cycle_count, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_block(block_out_o);
    end
  end

  function automatic logic [BlockW-1:0] rand_word();
    logic [BlockW-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = 64'd1 << $urandom_range(0, 63);
      3:       w = ~(64'd1 << $urandom_range(0, 63));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic send_block(input logic mode, input logic [BlockW-1:0] blk,
                            input logic [BlockW-1:0] key, input int unsigned idle_pct);
    int unsigned gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 2 * sb.active_rounds() + 4);
      start        <= 1'b0;
      mode_i       <= 1'($urandom_range(0, 1));
      block_in_i   <= rand_word();
      cipher_key_i <= rand_word();
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    mode_i       <= mode;
    block_in_i   <= blk;
    cipher_key_i <= key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_block(mode, blk, key);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_round_count(input bit [5:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ROUND_COUNT;
    pwdata  <= {26'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.round_count = value;
    settings_used++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.check_register(value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    bit [5:0]    phase_rounds [PHASE_COUNT];
    int unsigned idle_pct;

    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    start        <= 1'b0;
    mode_i       <= MODE_ENCRYPT;
    block_in_i   <= '0;
    cipher_key_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of four rounds, then zero rounds, one round, the maximum and saturation.
    send_block(MODE_ENCRYPT, '0, '0, 0);
    send_block(MODE_ENCRYPT, '1, '1, 0);
    send_block(MODE_ENCRYPT, '1, '0, 0);
    send_block(MODE_ENCRYPT, '0, '1, 0);
    send_block(MODE_DECRYPT, '0, '0, 0);
    send_block(MODE_DECRYPT, '1, '1, 0);
    send_block(MODE_ENCRYPT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    send_block(MODE_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 0);
    foreach (phase_rounds[p]) begin
      phase_rounds[p] = '0;
    end
    phase_rounds[1] = 6'd1;
    phase_rounds[2] = 6'd32;
    phase_rounds[3] = 6'd33;
    phase_rounds[4] = 6'd63;
    for (int p = 0; p < 5; p++) begin
      set_round_count(phase_rounds[p]);
      send_block(MODE_ENCRYPT, rand_word(), rand_word(), 0);
      send_block(MODE_DECRYPT, rand_word(), rand_word(), 0);
    end

    phase_rounds[0] = 6'd1;
    phase_rounds[1] = 6'd32;
    phase_rounds[2] = 6'd0;
    phase_rounds[3] = 6'($urandom_range(2, 31));
    phase_rounds[4] = 6'($urandom_range(33, 63));
    phase_rounds[5] = 6'($urandom_range(2, 31));
    for (int p = 0; p < PHASE_COUNT; p++) begin
      idle_pct = (p < 2) ? 28 : (p < 4) ? 63 : 0;
      set_round_count(phase_rounds[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_block($urandom_range(0, 1) ? MODE_DECRYPT : MODE_ENCRYPT,
                   rand_word(), rand_word(), idle_pct);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Checked %0d blocks (%0d encrypt, %0d decrypt) over %0d round-count writes.",
             sb.checked, sb.encrypted, sb.decrypted, settings_used);
    $display("Failures: %0d, blocks still outstanding: %0d", sb.failures, sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/nbc64_pkg.sv
rtl/core/nbc64_dp.sv
rtl/core/nbc64_ctrl.sv
rtl/core/nibble_block_cipher_64_top.sv
rtl/core/nbc64_checker.sv
bench/nibble_block_cipher_64_top_tb.sv
